// ===== design/bpad_pkg.sv =====
// Shared types, constants and helpers for the burst pattern alert detector.
package bpad_pkg;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW_LENGTH  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_HIGH_THRESHOLD = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_SHORT_LIMIT    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_MEDIUM_LIMIT   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_SHORT_COUNT    = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_MEDIUM_COUNT   = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] CFG_LONG_COUNT     = 3'd6;

  localparam logic [7:0]  WINDOW_LENGTH_RST  = 8'd100;
  localparam logic [7:0]  HIGH_THRESHOLD_RST = 8'd30;
  localparam logic [11:0] SHORT_LIMIT_RST    = 12'd1000;
  localparam logic [11:0] MEDIUM_LIMIT_RST   = 12'd2800;
  localparam logic [3:0]  SHORT_COUNT_RST    = 4'd2;
  localparam logic [3:0]  MEDIUM_COUNT_RST   = 4'd4;
  localparam logic [3:0]  LONG_COUNT_RST     = 4'd6;

  localparam logic [10:0] SERVO_REST   = 11'd781;
  localparam logic [10:0] SERVO_RAISED = 11'd1562;

  localparam logic [1:0] MS_IDLE    = 2'd0;
  localparam logic [1:0] MS_MONITOR = 2'd1;
  localparam logic [1:0] MS_ALERT   = 2'd2;

  localparam logic [1:0] LEVEL_SHORT  = 2'd0;
  localparam logic [1:0] LEVEL_MEDIUM = 2'd1;
  localparam logic [1:0] LEVEL_LONG   = 2'd2;

  typedef struct packed {
    logic [7:0]  window_length;
    logic [7:0]  high_tick_threshold;
    logic [11:0] short_level_limit;
    logic [11:0] medium_level_limit;
    logic [3:0]  short_burst_count;
    logic [3:0]  medium_burst_count;
    logic [3:0]  long_burst_count;
  } cfg_t;

  typedef struct packed {
    logic        person_present;
    logic        mic_high;
    logic        button_level;
    logic [11:0] pot_level;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  machine_state;
    logic        monitor_lamp;
    logic        red_led;
    logic [10:0] servo_pulse;
    logic        loud_burst;
    logic [3:0]  burst_number;
    logic        distress;
    logic        reset_pressed;
    logic [1:0]  level_code;
  } out_item_t;

  function automatic logic [7:0] sat_inc8(input logic [7:0] v);
    return (v == 8'hFF) ? v : v + 8'd1;
  endfunction

  function automatic logic [3:0] sat_inc4(input logic [3:0] v);
    return (v == 4'hF) ? v : v + 4'd1;
  endfunction

endpackage

// ===== design/bpad_cfg.sv =====
// Configuration register file, written through a plain write port.
module bpad_cfg
  import bpad_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_length       <= WINDOW_LENGTH_RST;
      cfg_r.high_tick_threshold <= HIGH_THRESHOLD_RST;
      cfg_r.short_level_limit   <= SHORT_LIMIT_RST;
      cfg_r.medium_level_limit  <= MEDIUM_LIMIT_RST;
      cfg_r.short_burst_count   <= SHORT_COUNT_RST;
      cfg_r.medium_burst_count  <= MEDIUM_COUNT_RST;
      cfg_r.long_burst_count    <= LONG_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_WINDOW_LENGTH:  cfg_r.window_length       <= cfg_wdata[7:0];
        CFG_HIGH_THRESHOLD: cfg_r.high_tick_threshold <= cfg_wdata[7:0];
        CFG_SHORT_LIMIT:    cfg_r.short_level_limit   <= cfg_wdata;
        CFG_MEDIUM_LIMIT:   cfg_r.medium_level_limit  <= cfg_wdata;
        CFG_SHORT_COUNT:    cfg_r.short_burst_count   <= cfg_wdata[3:0];
        CFG_MEDIUM_COUNT:   cfg_r.medium_burst_count  <= cfg_wdata[3:0];
        CFG_LONG_COUNT:     cfg_r.long_burst_count    <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== design/bpad_core.sv =====
// Window counting, level selection, burst tracking and mode state machine.
module bpad_core
  import bpad_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      fire,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output out_item_t res
);

  typedef enum logic [2:0] {
    ST_IDLE    = 3'b001,
    ST_MONITOR = 3'b010,
    ST_ALERT   = 3'b100
  } mode_t;

  typedef enum logic [1:0] {
    EV_NONE,
    EV_PRESENT,
    EV_DISTRESS,
    EV_RESET
  } event_t;

  mode_t      mode_r, mode_nxt;
  logic [7:0] high_cnt_r, high_cnt_nxt;
  logic [7:0] tick_r, tick_nxt;
  logic [3:0] burst_r, burst_nxt;
  logic [3:0] shown_r, shown_nxt;
  logic       btn_last_r;
  logic       loud;
  logic [1:0] level;
  logic [3:0] target;
  event_t     ev;

  always_comb begin
    high_cnt_nxt = high_cnt_r;
    tick_nxt     = tick_r;
    burst_nxt    = burst_r;
    shown_nxt    = shown_r;
    loud         = 1'b0;

    if (!item.person_present) begin
      high_cnt_nxt = '0;
      tick_nxt     = '0;
    end else begin
      if (item.mic_high) begin
        high_cnt_nxt = sat_inc8(high_cnt_r);
      end
      tick_nxt = sat_inc8(tick_r);
      if (tick_nxt >= cfg.window_length) begin
        if (high_cnt_nxt >= cfg.high_tick_threshold) begin
          loud      = 1'b1;
          burst_nxt = sat_inc4(burst_r);
          shown_nxt = sat_inc4(shown_r);
        end
        high_cnt_nxt = '0;
        tick_nxt     = '0;
      end
    end

    priority if (item.pot_level < cfg.short_level_limit) begin
      level  = LEVEL_SHORT;
      target = cfg.short_burst_count;
    end else if (item.pot_level < cfg.medium_level_limit) begin
      level  = LEVEL_MEDIUM;
      target = cfg.medium_burst_count;
    end else begin
      level  = LEVEL_LONG;
      target = cfg.long_burst_count;
    end

    priority if (btn_last_r && !item.button_level) begin
      ev = EV_RESET;
    end else if (burst_nxt >= target) begin
      ev = EV_DISTRESS;
    end else if (item.person_present) begin
      ev = EV_PRESENT;
    end else begin
      ev = EV_NONE;
    end

    if (ev == EV_RESET || ev == EV_DISTRESS) begin
      burst_nxt    = '0;
      high_cnt_nxt = '0;
      tick_nxt     = '0;
      shown_nxt    = '0;
    end

    unique case (mode_r)
      ST_IDLE:    mode_nxt = (ev == EV_PRESENT) ? ST_MONITOR : ST_IDLE;
      ST_MONITOR: begin
        unique case (ev)
          EV_PRESENT:  mode_nxt = ST_MONITOR;
          EV_DISTRESS: mode_nxt = ST_ALERT;
          default:     mode_nxt = ST_IDLE;
        endcase
      end
      ST_ALERT:   mode_nxt = (ev == EV_RESET) ? ST_IDLE : ST_ALERT;
      default:    mode_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= ST_IDLE;
      high_cnt_r <= '0;
      tick_r     <= '0;
      burst_r    <= '0;
      shown_r    <= '0;
      btn_last_r <= 1'b1;
    end else if (fire) begin
      mode_r     <= mode_nxt;
      high_cnt_r <= high_cnt_nxt;
      tick_r     <= tick_nxt;
      burst_r    <= burst_nxt;
      shown_r    <= shown_nxt;
      btn_last_r <= item.button_level;
    end
  end

  always_comb begin
    unique case (mode_nxt)
      ST_MONITOR: res.machine_state = MS_MONITOR;
      ST_ALERT:   res.machine_state = MS_ALERT;
      default:    res.machine_state = MS_IDLE;
    endcase
    res.monitor_lamp  = (mode_nxt == ST_MONITOR);
    res.red_led       = (mode_nxt == ST_ALERT);
    res.servo_pulse   = (mode_nxt == ST_ALERT) ? SERVO_RAISED : SERVO_REST;
    res.loud_burst    = loud;
    res.burst_number  = shown_nxt;
    res.distress      = (ev == EV_DISTRESS);
    res.reset_pressed = (ev == EV_RESET);
    res.level_code    = level;
  end

  a_distress_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.distress |=> burst_r == '0 && shown_r == '0 && tick_r == '0)
    else $error("distress did not clear counters");

  a_absent_clears_window: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !item.person_present |=> high_cnt_r == '0 && tick_r == '0)
    else $error("window counts kept without presence");

  a_press_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.reset_pressed |=> mode_r == ST_IDLE && burst_r == '0)
    else $error("button press did not return to idle");

  a_alert_entry: assert property (@(posedge clk) disable iff (!rst_n)
    fire && mode_r == ST_IDLE |-> mode_nxt != ST_ALERT)
    else $error("alert entered directly from idle");

endmodule

// ===== design/burst_pattern_alert_detector_unit.sv =====
// Top level of the burst pattern alert detector.
// Input register, then result register. Throughput: one transaction per cycle while the
// output is not stalled; all per-tick updates settle in one combinational pass.
// Reset: synchronous active-low rst_n clears the mode machine, counters and valids and
// reloads the configuration registers with their defaults.
module burst_pattern_alert_detector_unit
  import bpad_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t      cfg;
  in_item_t  in_r;
  logic      in_valid_r;
  out_item_t out_r;
  out_item_t res;
  logic      out_valid_r;
  logic      out_free;
  logic      fire;
  logic      in_take;

  assign out_free = !out_valid_r || !out_stall;
  assign fire     = in_valid_r && out_free;
  assign in_stall = in_valid_r && !fire;
  assign in_take  = in_valid && !in_stall;

  bpad_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .cfg      (cfg)
  );

  bpad_core u_core (
    .clk  (clk),
    .rst_n(rst_n),
    .fire (fire),
    .item (in_r),
    .cfg  (cfg),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_r <= 1'b1;
      end else if (fire) begin
        in_valid_r <= 1'b0;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_r <= in_data;
    end
    if (fire) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_led_servo: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_r.red_led == (out_r.servo_pulse == SERVO_RAISED))
    else $error("servo pulse disagrees with alert lamp");

  a_one_lamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.red_led && out_r.monitor_lamp))
    else $error("both lamps lit");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |-> !fire)
    else $error("result overwritten while stalled");

endmodule

// ===== bench/bpad_alert_check_pkg.sv =====
`timescale 1ns / 100ps
// Scoreboard with a tick-level predictor for the burst pattern alert detector bench.
package bpad_alert_check_pkg;
  import bpad_pkg::*;

  class alert_scoreboard;
    cfg_t       regs;
    logic [1:0] mode;
    logic [7:0] loud_ticks;
    logic [7:0] window_ticks;
    logic [3:0] bursts;
    logic [3:0] shown_bursts;
    logic       last_button;
    out_item_t  pending_results[$];
    int         errors;

    function new();
      regs = '{WINDOW_LENGTH_RST, HIGH_THRESHOLD_RST, SHORT_LIMIT_RST, MEDIUM_LIMIT_RST,
               SHORT_COUNT_RST, MEDIUM_COUNT_RST, LONG_COUNT_RST};
      mode = MS_IDLE;
      loud_ticks = '0;
      window_ticks = '0;
      bursts = '0;
      shown_bursts = '0;
      last_button = 1'b1;
      errors = 0;
    endfunction

    function void set_regs(input cfg_t c);
      regs = c;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    // Advance the predicted state by one accepted tick and queue the expected result.
    function void log_tick(input in_item_t it);
      out_item_t  r;
      logic [3:0] target;
      r = '0;

      if (!it.person_present) begin
        loud_ticks = '0;
        window_ticks = '0;
      end else begin
        if (it.mic_high && loud_ticks != 8'hFF) loud_ticks = loud_ticks + 8'd1;
        if (window_ticks != 8'hFF) window_ticks = window_ticks + 8'd1;
        if (window_ticks >= regs.window_length) begin
          if (loud_ticks >= regs.high_tick_threshold) begin
            r.loud_burst = 1'b1;
            if (bursts != 4'hF) bursts = bursts + 4'd1;
            if (shown_bursts != 4'hF) shown_bursts = shown_bursts + 4'd1;
          end
          loud_ticks = '0;
          window_ticks = '0;
        end
      end

      if (it.pot_level < regs.short_level_limit) begin
        r.level_code = LEVEL_SHORT;
        target = regs.short_burst_count;
      end else if (it.pot_level < regs.medium_level_limit) begin
        r.level_code = LEVEL_MEDIUM;
        target = regs.medium_burst_count;
      end else begin
        r.level_code = LEVEL_LONG;
        target = regs.long_burst_count;
      end

      if (last_button && !it.button_level) begin
        r.reset_pressed = 1'b1;
        bursts = '0;
        shown_bursts = '0;
        loud_ticks = '0;
        window_ticks = '0;
        mode = MS_IDLE;
      end else if (bursts >= target) begin
        r.distress = 1'b1;
        bursts = '0;
        shown_bursts = '0;
        loud_ticks = '0;
        window_ticks = '0;
        // distress in idle keeps idle
        if (mode != MS_IDLE) mode = MS_ALERT;
      end else if (it.person_present) begin
        if (mode != MS_ALERT) mode = MS_MONITOR;
      end else begin
        if (mode != MS_ALERT) mode = MS_IDLE;
      end
      last_button = it.button_level;

      r.machine_state = mode;
      r.monitor_lamp = (mode == MS_MONITOR);
      r.red_led = (mode == MS_ALERT);
      r.servo_pulse = (mode == MS_ALERT) ? SERVO_RAISED : SERVO_REST;
      r.burst_number = shown_bursts;
      pending_results.push_back(r);
    endfunction

    task report(input string what, input int got, input int want);
      if (errors < 50) $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
      errors++;
    endtask

    task check_tick(input out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        report("result transaction with nothing outstanding", int'(got), 0);
      end else begin
        want = pending_results.pop_front();
        if (got.machine_state !== want.machine_state)
          report("machine_state", int'(got.machine_state), int'(want.machine_state));
        if (got.monitor_lamp !== want.monitor_lamp)
          report("monitor_lamp", int'(got.monitor_lamp), int'(want.monitor_lamp));
        if (got.red_led !== want.red_led)
          report("red_led", int'(got.red_led), int'(want.red_led));
        if (got.servo_pulse !== want.servo_pulse)
          report("servo_pulse", int'(got.servo_pulse), int'(want.servo_pulse));
        if (got.loud_burst !== want.loud_burst)
          report("loud_burst", int'(got.loud_burst), int'(want.loud_burst));
        if (got.burst_number !== want.burst_number)
          report("burst_number", int'(got.burst_number), int'(want.burst_number));
        if (got.distress !== want.distress)
          report("distress", int'(got.distress), int'(want.distress));
        if (got.reset_pressed !== want.reset_pressed)
          report("reset_pressed", int'(got.reset_pressed), int'(want.reset_pressed));
        if (got.level_code !== want.level_code)
          report("level_code", int'(got.level_code), int'(want.level_code));
      end
    endtask
  endclass

endpackage

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// Top-level bench: drives sample ticks and settings into the detector and checks each result.
module tb_top
  import bpad_pkg::*, bpad_alert_check_pkg::*;
();

  localparam int IDLE_PCT   = 6;
  localparam int IDLE_LIMIT = 2000;

  localparam logic [CFG_ADDR_W-1:0] REG_ORDER [7] = '{
    CFG_WINDOW_LENGTH, CFG_HIGH_THRESHOLD, CFG_SHORT_LIMIT, CFG_MEDIUM_LIMIT,
    CFG_SHORT_COUNT, CFG_MEDIUM_COUNT, CFG_LONG_COUNT
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  quiet = 1'b0;
  int                    idle_cycles = 0;
  alert_scoreboard       sb;

  always #5 clk = ~clk;

  burst_pattern_alert_detector_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // transaction monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.log_tick(in_data);
      if (out_valid && !out_stall) sb.check_tick(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic in_item_t tick_of(input logic present, input logic mic,
                                       input logic button, input logic [11:0] pot);
    in_item_t it;
    it.person_present = present;
    it.mic_high = mic;
    it.button_level = button;
    it.pot_level = pot;
    return it;
  endfunction

  function automatic logic [11:0] pick_pot();
    case ($urandom_range(0, 6))
      0: return sb.regs.short_level_limit - 12'd1;
      1: return sb.regs.short_level_limit;
      2: return sb.regs.medium_level_limit - 12'd1;
      3: return sb.regs.medium_level_limit;
      default: return 12'($urandom_range(0, 4095));
    endcase
  endfunction

  task automatic send_tick(input in_item_t it);
    if (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 40);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_settings(input cfg_t c);
    logic [CFG_DATA_W-1:0] v;
    for (int i = 0; i < 7; i++) begin
      case (REG_ORDER[i])
        CFG_WINDOW_LENGTH:  v = CFG_DATA_W'(c.window_length);
        CFG_HIGH_THRESHOLD: v = CFG_DATA_W'(c.high_tick_threshold);
        CFG_SHORT_LIMIT:    v = c.short_level_limit;
        CFG_MEDIUM_LIMIT:   v = c.medium_level_limit;
        CFG_SHORT_COUNT:    v = CFG_DATA_W'(c.short_burst_count);
        CFG_MEDIUM_COUNT:   v = CFG_DATA_W'(c.medium_burst_count);
        default:            v = CFG_DATA_W'(c.long_burst_count);
      endcase
      cfg_we <= 1'b1;
      cfg_addr <= REG_ORDER[i];
      cfg_wdata <= v;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    sb.set_regs(c);
  endtask

  // Runs of steady presence with random loudness, plus some fully random noise runs.
  task automatic run_random(input int n_items);
    in_item_t    it;
    logic [31:0] raw;
    logic [11:0] run_pot;
    int          left;
    int          run_len;
    int          loud_pct;
    bit          noisy;
    left = n_items;
    while (left > 0) begin
      run_len = $urandom_range(8, 40);
      noisy = ($urandom_range(0, 99) < 15);
      loud_pct = $urandom_range(20, 95);
      run_pot = pick_pot();
      for (int k = 0; k < run_len && left > 0; k++) begin
        if (noisy) begin
          raw = $urandom;
          it = raw[$bits(in_item_t)-1:0];
        end else begin
          it.person_present = ($urandom_range(0, 99) < 97);
          it.mic_high = ($urandom_range(0, 99) < loud_pct);
          it.button_level = ($urandom_range(0, 99) >= 2);
          it.pot_level = ($urandom_range(0, 99) < 80) ? run_pot : pick_pot();
        end
        send_tick(it);
        left--;
        if (left == n_items / 2) wait_drained();
      end
    end
  endtask

  initial begin
    cfg_t c;
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: level boundaries, button edge, presence loss
    send_tick(tick_of(1'b0, 1'b0, 1'b1, 12'd0));
    send_tick(tick_of(1'b1, 1'b1, 1'b1, 12'd4095));
    send_tick(tick_of(1'b1, 1'b0, 1'b1, 12'd999));
    send_tick(tick_of(1'b1, 1'b1, 1'b1, 12'd1000));
    send_tick(tick_of(1'b1, 1'b0, 1'b1, 12'd2799));
    send_tick(tick_of(1'b1, 1'b1, 1'b1, 12'd2800));
    send_tick(tick_of(1'b1, 1'b1, 1'b0, 12'd500));
    send_tick(tick_of(1'b1, 1'b1, 1'b0, 12'd500));
    send_tick(tick_of(1'b0, 1'b1, 1'b1, 12'd3000));
    wait_drained();

    // one-tick windows: distress, burst with reset, distress while idle
    c = '{8'd1, 8'd1, 12'd0, 12'd4095, 4'd15, 4'd2, 4'd1};
    load_settings(c);
    send_tick(tick_of(1'b1, 1'b1, 1'b1, 12'd100));
    send_tick(tick_of(1'b1, 1'b1, 1'b1, 12'd100));
    send_tick(tick_of(1'b1, 1'b0, 1'b1, 12'd100));
    send_tick(tick_of(1'b1, 1'b1, 1'b0, 12'd100));
    send_tick(tick_of(1'b0, 1'b0, 1'b1, 12'd100));
    send_tick(tick_of(1'b1, 1'b1, 1'b1, 12'd4095));
    wait_drained();

    // zero window, zero target, limits out of order
    c = '{8'd0, 8'd0, 12'd2000, 12'd1000, 4'd0, 4'd7, 4'd15};
    load_settings(c);
    send_tick(tick_of(1'b0, 1'b0, 1'b1, 12'd1500));
    send_tick(tick_of(1'b1, 1'b1, 1'b1, 12'd2500));
    send_tick(tick_of(1'b1, 1'b0, 1'b1, 12'd2500));
    send_tick(tick_of(1'b1, 1'b1, 1'b1, 12'd0));
    send_tick(tick_of(1'b1, 1'b1, 1'b1, 12'd4095));
    send_tick(tick_of(1'b0, 1'b1, 1'b0, 12'd4095));
    wait_drained();

    c = '{8'd3, 8'd2, 12'd1000, 12'd2800, 4'd2, 4'd4, 4'd6};
    load_settings(c);
    run_random(100);
    wait_drained();

    c = '{8'd255, 8'd255, 12'd4095, 12'd4095, 4'd15, 4'd15, 4'd15};
    load_settings(c);
    run_random(60);
    wait_drained();

    c = '{8'd1, 8'd0, 12'd0, 12'd0, 4'd1, 4'd1, 4'd15};
    load_settings(c);
    quiet <= 1'b1;
    run_random(90);
    quiet <= 1'b0;
    wait_drained();

    c.window_length = 8'($urandom_range(2, 8));
    c.high_tick_threshold = 8'($urandom_range(0, c.window_length));
    c.short_level_limit = 12'($urandom_range(0, 4095));
    c.medium_level_limit = 12'($urandom_range(0, 4095));
    c.short_burst_count = 4'($urandom_range(1, 15));
    c.medium_burst_count = 4'($urandom_range(1, 15));
    c.long_burst_count = 4'($urandom_range(1, 15));
    load_settings(c);
    run_random(100);
    wait_drained();

    c = '{8'd6, 8'd4, 12'd2048, 12'd3072, 4'd3, 4'd5, 4'd8};
    load_settings(c);
    run_random(80);
    wait_drained();
    repeat (4) @(posedge clk);

    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/bpad_pkg.sv
design/bpad_cfg.sv
design/bpad_core.sv
design/burst_pattern_alert_detector_unit.sv
bench/bpad_alert_check_pkg.sv
bench/tb_top.sv
